>>> hdl/tdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// shared constants, codes and controller/datapath link types for the
// triangle depth rasterizer
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int STORE_WIDTH_DEF  = 256;
    localparam int STORE_HEIGHT_DEF = 256;

    localparam logic [23:0] EMPTY_DEPTH = 24'hFFFFFF;
    localparam logic [23:0] MAX_DRAWN   = 24'hFFFFFE;

    // quotient bits of a fraction (0..65536)
    localparam int QB  = 17;
    // divider operand width, holds any edge x span in q.20
    localparam int DW  = 36;
    // pixel column width, signed, before clipping
    localparam int PXW = 18;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_issue;
        logic row_init;
        logic row_next;
        logic edge_init;
        logic edge_skip;
        logic div_edge;
        logic mul_edge;
        logic edge_store;
        logic span_setup;
        logic div_pix;
        logic mul_pix;
        logic pix_write;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic edge_end;
        logic have_two;
        logic crosses;
        logic div_done;
        logic span_end;
        logic span_flat;
        logic last_row;
    } dp_sts_t;

    // floor(max(z0*65536 + prod, 0) / 65536)
    function automatic logic [23:0] lerp_out(input logic [23:0] z0,
                                             input logic signed [42:0] prod);
        logic signed [42:0] s;
        s = $signed({3'b000, z0, 16'h0000}) + prod;
        if (s[42]) begin
            return 24'h000000;
        end
        return s[39:16];
    endfunction

endpackage

>>> hdl/tdr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_div
// restoring divider giving floor(num*65536/den) for num <= den, one bit a cycle
// ----------------------------------------------------------------------------
module tdr_div
    import tdr_pkg::*;
#(
    parameter int DIV_W = DW
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [QB-1:0]    quo
);

    localparam int CW = $clog2(QB + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             first_reg;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [QB-1:0]    quo_reg;
    logic [DIV_W:0]   shifted;
    logic             ge;

    assign shifted = first_reg ? rem_reg : {rem_reg[DIV_W-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};
    assign done    = (cnt_reg == '0);
    assign quo     = quo_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = CW'(QB);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {1'b0, num};
            den_reg   <= den;
            first_reg <= 1'b1;
            quo_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg   <= ge ? shifted - {1'b0, den_reg} : shifted;
            first_reg <= 1'b0;
            quo_reg   <= {quo_reg[QB-2:0], ge};
        end
    end

endmodule

>>> hdl/tdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_ctrl
// sequencer for clear, draw and read commands and the result word handshake
// ----------------------------------------------------------------------------
module tdr_ctrl
    import tdr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [4:0] {
        S_CLR_RST, S_IDLE, S_DISPATCH, S_CLR_OP, S_READ, S_READ_WAIT,
        S_ROW, S_EDGE, S_EDIV, S_EMUL, S_EADD, S_SPAN,
        S_PIX, S_PDIV, S_PMUL, S_PCMP, S_NEXT_ROW, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_RST: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_CLEAR: state_next = S_CLR_OP;
                    OP_DRAW: begin
                        cmd.row_init = 1'b1;
                        state_next   = S_ROW;
                    end
                    OP_READ:  state_next = S_READ;
                    default:  state_next = S_DONE;
                endcase
            end
            S_CLR_OP: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_READ_WAIT;
            end
            S_READ_WAIT: state_next = S_DONE;
            S_ROW: begin
                cmd.edge_init = 1'b1;
                state_next    = S_EDGE;
            end
            S_EDGE: begin
                if (sts.edge_end) begin
                    state_next = sts.have_two ? S_SPAN : S_NEXT_ROW;
                end else if (sts.crosses) begin
                    cmd.div_edge = 1'b1;
                    state_next   = S_EDIV;
                end else begin
                    cmd.edge_skip = 1'b1;
                end
            end
            S_EDIV: begin
                if (sts.div_done) begin
                    state_next = S_EMUL;
                end
            end
            S_EMUL: begin
                cmd.mul_edge = 1'b1;
                state_next   = S_EADD;
            end
            S_EADD: begin
                cmd.edge_store = 1'b1;
                state_next     = S_EDGE;
            end
            S_SPAN: begin
                cmd.span_setup = 1'b1;
                state_next     = S_PIX;
            end
            S_PIX: begin
                if (sts.span_end) begin
                    state_next = S_NEXT_ROW;
                end else if (sts.span_flat) begin
                    state_next = S_PMUL;
                end else begin
                    cmd.div_pix = 1'b1;
                    state_next  = S_PDIV;
                end
            end
            S_PDIV: begin
                if (sts.div_done) begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL: begin
                cmd.mul_pix = 1'b1;
                state_next  = S_PCMP;
            end
            S_PCMP: begin
                cmd.pix_write = 1'b1;
                state_next    = S_PIX;
            end
            S_NEXT_ROW: begin
                if (sts.last_row) begin
                    state_next = S_DONE;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next   = S_ROW;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hdl/tdr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_dp
// depth store, edge and span interpolation, shared divider and result word
// ----------------------------------------------------------------------------
module tdr_dp
    import tdr_pkg::*;
#(
    parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = STORE_HEIGHT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_ax,
    input  logic signed [15:0] s_ay,
    input  logic [23:0]        s_az,
    input  logic signed [15:0] s_bx,
    input  logic signed [15:0] s_by_coord,
    input  logic [23:0]        s_bz,
    input  logic signed [15:0] s_cx_coord,
    input  logic signed [15:0] s_cy_coord,
    input  logic [23:0]        s_cz,
    input  logic [7:0]         s_read_col,
    input  logic [7:0]         s_read_row,
    output logic [23:0]        m_read_depth,
    output logic               m_is_empty
);

    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(STORE_HEIGHT);
    localparam logic signed [PXW-1:0] X_MAX = PXW'(STORE_WIDTH - 1);

    // command word
    logic signed [15:0] vx_reg [3];
    logic signed [15:0] vy_reg [3];
    logic [23:0]        vz_reg [3];
    op_t                op_reg;
    logic [7:0]         rcol_reg, rrow_reg;

    // walk counters
    logic [AW-1:0] clr_addr_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] row_base_reg;
    logic [1:0]    edge_reg, cnt_reg;
    logic signed [PXW-1:0] x_reg, x1_reg;

    // interpolation
    logic signed [34:0]   pxe_reg;
    logic signed [42:0]   pz_reg;
    logic signed [DW-1:0] xe_reg [2];
    logic [23:0]          ze_reg [2];
    logic signed [DW-1:0] xl_reg, xr_reg;
    logic [23:0]          zl_reg, zr_reg;
    logic [DW-1:0]        sp_reg;
    logic                 in_range_reg;

    // store
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0] mem_wdata;

    logic [23:0] read_depth_reg;
    logic        is_empty_reg;

    // edge selection
    logic signed [15:0] xa, xb, ya, yb;
    logic [23:0]        za, zb;
    logic signed [17:0] fy, ya18, yb18, num, den;
    logic [17:0]        an, ad;
    logic signed [16:0] dx;
    logic signed [24:0] dz, dzp;

    logic [DW-1:0]   div_num, div_den;
    logic            div_done;
    logic [QB-1:0]   quo, uq;

    logic                 swap;
    logic signed [DW-1:0] xl_c, xr_c, ng, cl;
    logic [23:0]          zl_c, zr_c;
    logic signed [PXW-1:0] x0_raw, x1_raw;
    logic signed [37:0]   pix_d;
    logic [AW-1:0]        pix_addr, rd_addr;
    logic [23:0]          zp, zs;
    logic                 pix_wr;

    always_comb begin
        unique case (edge_reg)
            2'd1: begin
                xa = vx_reg[1]; ya = vy_reg[1]; za = vz_reg[1];
                xb = vx_reg[2]; yb = vy_reg[2]; zb = vz_reg[2];
            end
            2'd2: begin
                xa = vx_reg[2]; ya = vy_reg[2]; za = vz_reg[2];
                xb = vx_reg[0]; yb = vy_reg[0]; zb = vz_reg[0];
            end
            default: begin
                xa = vx_reg[0]; ya = vy_reg[0]; za = vz_reg[0];
                xb = vx_reg[1]; yb = vy_reg[1]; zb = vz_reg[1];
            end
        endcase
    end

    // row centre in q.4
    assign fy   = signed'(18'({row_reg, 4'h8}));
    assign ya18 = 18'(ya);
    assign yb18 = 18'(yb);
    assign num  = fy - ya18;
    assign den  = yb18 - ya18;
    assign an   = num[17] ? unsigned'(-num) : unsigned'(num);
    assign ad   = den[17] ? unsigned'(-den) : unsigned'(den);
    assign dx   = 17'(xb) - 17'(xa);
    assign dz   = $signed({1'b0, zb}) - $signed({1'b0, za});
    assign dzp  = $signed({1'b0, zr_reg}) - $signed({1'b0, zl_reg});

    assign pix_d   = $signed({x_reg, 20'h00000}) - 38'(xl_reg);
    assign div_num = cmd.div_pix ? DW'(pix_d) : DW'(an);
    assign div_den = cmd.div_pix ? sp_reg : DW'(ad);

    tdr_div #(
        .DIV_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_edge | cmd.div_pix),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    assign uq = (sp_reg == '0) ? '0 : quo;

    // sort the two crossings and find the covered columns
    assign swap   = xe_reg[0] > xe_reg[1];
    assign xl_c   = swap ? xe_reg[1] : xe_reg[0];
    assign xr_c   = swap ? xe_reg[0] : xe_reg[1];
    assign zl_c   = swap ? ze_reg[1] : ze_reg[0];
    assign zr_c   = swap ? ze_reg[0] : ze_reg[1];
    assign ng     = -xl_c;
    assign cl     = ng >>> 20;
    assign x0_raw = -PXW'(cl);
    assign x1_raw = PXW'(xr_c >>> 20);

    assign pix_addr = row_base_reg + AW'(x_reg);
    assign rd_addr  = AW'(32'(rrow_reg) * STORE_WIDTH + 32'(rcol_reg));

    assign zp     = lerp_out(zl_reg, pz_reg);
    assign zs     = (zp == EMPTY_DEPTH) ? MAX_DRAWN : zp;
    assign pix_wr = cmd.pix_write && (zs < rd_data_reg);

    assign mem_we    = cmd.clr_step | pix_wr;
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : pix_addr;
    assign mem_wdata = cmd.clr_step ? EMPTY_DEPTH : zs;
    assign mem_re    = cmd.rd_issue | cmd.mul_pix;
    assign mem_raddr = cmd.rd_issue ? rd_addr : pix_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            edge_reg     <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.row_init) begin
                row_reg      <= '0;
                row_base_reg <= '0;
            end else if (cmd.row_next) begin
                row_reg      <= row_reg + 1'b1;
                row_base_reg <= row_base_reg + AW'(STORE_WIDTH);
            end
            if (cmd.edge_init) begin
                edge_reg <= '0;
                cnt_reg  <= '0;
            end else if (cmd.edge_skip) begin
                edge_reg <= edge_reg + 1'b1;
            end else if (cmd.edge_store) begin
                edge_reg <= edge_reg + 1'b1;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= op_t'(s_op);
            vx_reg[0] <= s_ax;       vy_reg[0] <= s_ay;       vz_reg[0] <= s_az;
            vx_reg[1] <= s_bx;       vy_reg[1] <= s_by_coord; vz_reg[1] <= s_bz;
            vx_reg[2] <= s_cx_coord; vy_reg[2] <= s_cy_coord; vz_reg[2] <= s_cz;
            rcol_reg  <= s_read_col;
            rrow_reg  <= s_read_row;
        end
        if (cmd.mul_edge) begin
            pxe_reg <= $signed({1'b0, quo}) * dx;
            pz_reg  <= $signed({1'b0, quo}) * dz;
        end else if (cmd.mul_pix) begin
            pz_reg  <= $signed({1'b0, uq}) * dzp;
        end
        if (cmd.edge_store) begin
            xe_reg[cnt_reg[0]] <= (DW'(xa) <<< 16) + DW'(pxe_reg);
            ze_reg[cnt_reg[0]] <= lerp_out(za, pz_reg);
        end
        if (cmd.span_setup) begin
            xl_reg <= xl_c;
            xr_reg <= xr_c;
            zl_reg <= zl_c;
            zr_reg <= zr_c;
            sp_reg <= DW'(xr_c - xl_c);
            x_reg  <= x0_raw[PXW-1] ? '0 : x0_raw;
            x1_reg <= (x1_raw > X_MAX) ? X_MAX : x1_raw;
        end else if (cmd.pix_write) begin
            x_reg  <= x_reg + 1'b1;
        end
        if (cmd.rd_issue) begin
            in_range_reg <= (32'(rcol_reg) < STORE_WIDTH) && (32'(rrow_reg) < STORE_HEIGHT);
        end
        if (cmd.out_load) begin
            if (op_reg == OP_READ) begin
                read_depth_reg <= in_range_reg ? rd_data_reg : EMPTY_DEPTH;
                is_empty_reg   <= !in_range_reg || (rd_data_reg == EMPTY_DEPTH);
            end else begin
                read_depth_reg <= '0;
                is_empty_reg   <= 1'b0;
            end
        end
    end

    // xr is kept with the span and checked against xl so that an inverted span ends
    logic span_ok;
    assign span_ok = (xr_reg >= xl_reg);

    always_comb begin
        sts.op        = op_reg;
        sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
        sts.edge_end  = (edge_reg == 2'd3) || (cnt_reg == 2'd2);
        sts.have_two  = (cnt_reg == 2'd2);
        sts.crosses   = ((ya18 <= fy) && (yb18 > fy)) || ((yb18 <= fy) && (ya18 > fy));
        sts.div_done  = div_done;
        sts.span_end  = (x_reg > x1_reg) || !span_ok;
        sts.span_flat = (sp_reg == '0);
        sts.last_row  = (row_reg == RW'(STORE_HEIGHT - 1));
    end

    assign m_read_depth = read_depth_reg;
    assign m_is_empty   = is_empty_reg;

endmodule

>>> hdl/triangle_depth_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer
// scanline triangle rasteriser with a depth store: clear, draw and read
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------
//  input   | s_valid / s_ready  | op, three vertices (x, y q12.4; z q8.16),
//          |                    | read column and row
//  result  | m_valid / m_ready  | read_depth, is_empty (one word per command)
//
//  draw: per row, one shared-divider fraction for each crossing edge, and
//    one for each drawn pixel of a span that is not flat
//  reset: a clearing pass fills the store with the empty value; no word is
//    taken until it ends
//  stalls: a finished result waits in the output register while the next
//    word is taken; a command finishing before it is taken holds its result
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer
    import tdr_pkg::*;
#(
    parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = STORE_HEIGHT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_ax,
    input  logic signed [15:0] s_ay,
    input  logic [23:0]        s_az,
    input  logic signed [15:0] s_bx,
    input  logic signed [15:0] s_by_coord,
    input  logic [23:0]        s_bz,
    input  logic signed [15:0] s_cx_coord,
    input  logic signed [15:0] s_cy_coord,
    input  logic [23:0]        s_cz,
    input  logic [7:0]         s_read_col,
    input  logic [7:0]         s_read_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_read_depth,
    output logic               m_is_empty
);

    // controller to datapath commands and returned status
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: command decode, row and pixel walk, result handshake
    tdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath: depth store, edge and span interpolation, result register
    tdr_dp #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_az         (s_az),
        .s_bx         (s_bx),
        .s_by_coord   (s_by_coord),
        .s_bz         (s_bz),
        .s_cx_coord   (s_cx_coord),
        .s_cy_coord   (s_cy_coord),
        .s_cz         (s_cz),
        .s_read_col   (s_read_col),
        .s_read_row   (s_read_row),
        .m_read_depth (m_read_depth),
        .m_is_empty   (m_is_empty)
    );

endmodule

>>> bench/tb_triangle_depth_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_depth_rasterizer
// self-checking bench: a directed table then constrained-random words are
// driven through the valid/ready input channel, a behavioural mirror of the
// depth store predicts the untyped results, and a monitor compares each one
// ----------------------------------------------------------------------------
module tb_triangle_depth_rasterizer;
    import tdr_pkg::*;

    localparam int NUM_RANDOM = 680;
    localparam int SIDE       = 256;

    // one command word as driven on the input channel
    typedef struct {
        op_t                op;
        logic signed [15:0] ax, ay, bx, by, cx, cy;
        logic [23:0]        az, bz, cz;
        logic [7:0]         col, row;
        bit                 typed;
        logic [23:0]        typed_depth;
        logic               typed_empty;
    } cmd_word_t;

    typedef struct {
        logic [23:0] depth;
        logic        empty;
    } depth_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_NONE;
    logic signed [15:0] s_ax = '0, s_ay = '0, s_bx = '0, s_by_coord = '0;
    logic signed [15:0] s_cx_coord = '0, s_cy_coord = '0;
    logic [23:0]        s_az = '0, s_bz = '0, s_cz = '0;
    logic [7:0]         s_read_col = '0, s_read_row = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [23:0]        m_read_depth;
    logic               m_is_empty;

    // mirror of the block's depth store and the results still owed
    logic [23:0]   depth_mirror [0:SIDE*SIDE-1];
    depth_result_t owed_results [$];
    cmd_word_t     directed_rows [$];
    int            fail_count = 0;
    bit            sending_done = 1'b0;

    triangle_depth_rasterizer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_ax(s_ax), .s_ay(s_ay), .s_az(s_az),
        .s_bx(s_bx), .s_by_coord(s_by_coord), .s_bz(s_bz),
        .s_cx_coord(s_cx_coord), .s_cy_coord(s_cy_coord), .s_cz(s_cz),
        .s_read_col(s_read_col), .s_read_row(s_read_row),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_read_depth(m_read_depth), .m_is_empty(m_is_empty)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // depth between z0 and z1 at q0.16 fraction t, floored at zero
    function automatic longint blend_depth(longint z0, longint z1, longint t);
        longint s;
        s = z0 * 65536 + t * (z1 - z0);
        if (s < 0) s = 0;
        return s >>> 16;
    endfunction

    function automatic longint floor_q20(longint v);
        if (v >= 0) return v >>> 20;
        return -((-v + 64'hFFFFF) >>> 20);
    endfunction

    function automatic void draw_into_mirror(cmd_word_t w);
        longint vx [3], vy [3], vz [3];
        longint xe [2], ze [2];
        longint fy, ya, yb, an, ad, t, x0, x1, sp, u, z, tmp;
        int     cnt, i, j;
        vx[0] = longint'(w.ax); vy[0] = longint'(w.ay); vz[0] = longint'(w.az);
        vx[1] = longint'(w.bx); vy[1] = longint'(w.by); vz[1] = longint'(w.bz);
        vx[2] = longint'(w.cx); vy[2] = longint'(w.cy); vz[2] = longint'(w.cz);
        for (int y = 0; y < SIDE; y++) begin
            // sample at the row centre, half-open crossing test per edge
            fy  = y * 16 + 8;
            cnt = 0;
            for (int e = 0; e < 3 && cnt < 2; e++) begin
                i  = e;
                j  = (e + 1) % 3;
                ya = vy[i];
                yb = vy[j];
                if ((ya <= fy && yb > fy) || (yb <= fy && ya > fy)) begin
                    an = (fy - ya < 0) ? ya - fy : fy - ya;
                    ad = (yb - ya < 0) ? ya - yb : yb - ya;
                    t  = (an * 65536) / ad;
                    xe[cnt] = vx[i] * 65536 + t * (vx[j] - vx[i]);
                    ze[cnt] = blend_depth(vz[i], vz[j], t);
                    cnt++;
                end
            end
            if (cnt == 2) begin
                if (xe[0] > xe[1]) begin
                    tmp = xe[0]; xe[0] = xe[1]; xe[1] = tmp;
                    tmp = ze[0]; ze[0] = ze[1]; ze[1] = tmp;
                end
                x0 = -floor_q20(-xe[0]);
                x1 = floor_q20(xe[1]);
                sp = xe[1] - xe[0];
                if (x0 < 0) x0 = 0;
                if (x1 > SIDE - 1) x1 = SIDE - 1;
                for (longint x = x0; x <= x1; x++) begin
                    u = 0;
                    if (sp > 0) u = ((x * 1048576 - xe[0]) * 65536) / sp;
                    z = blend_depth(ze[0], ze[1], u);
                    if (z > longint'(MAX_DRAWN)) z = longint'(MAX_DRAWN);
                    if (z < longint'(depth_mirror[y * SIDE + x]))
                        depth_mirror[y * SIDE + x] = z[23:0];
                end
            end
        end
    endfunction

    // applies one accepted word to the mirror and gives the result it owes
    function automatic depth_result_t rasterise_word(cmd_word_t w);
        depth_result_t r;
        r.depth = '0;
        r.empty = 1'b0;
        case (w.op)
            OP_CLEAR: begin
                foreach (depth_mirror[k]) depth_mirror[k] = EMPTY_DEPTH;
            end
            OP_DRAW: begin
                draw_into_mirror(w);
            end
            OP_READ: begin
                r.depth = depth_mirror[int'(w.row) * SIDE + int'(w.col)];
                r.empty = (r.depth == EMPTY_DEPTH);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(50, 300);
    endfunction

    function automatic cmd_word_t blank_word(op_t op);
        cmd_word_t w;
        w.op  = op;
        w.ax  = 16'($urandom); w.ay = 16'($urandom); w.bx = 16'($urandom);
        w.by  = 16'($urandom); w.cx = 16'($urandom); w.cy = 16'($urandom);
        w.az  = 24'($urandom); w.bz = 24'($urandom); w.cz = 24'($urandom);
        w.col = 8'($urandom);  w.row = 8'($urandom);
        w.typed = 1'b0;
        w.typed_depth = '0;
        w.typed_empty = 1'b0;
        return w;
    endfunction

    function automatic void add_row(cmd_word_t w, bit typed, logic [23:0] d, logic e);
        w.typed       = typed;
        w.typed_depth = d;
        w.typed_empty = e;
        directed_rows.insert(directed_rows.size(), w);
    endfunction

    function automatic cmd_word_t tri_word(int ax, int ay, int az, int bx, int by,
                                           int bz, int cx, int cy, int cz);
        cmd_word_t w;
        w = blank_word(OP_DRAW);
        w.ax = 16'(ax); w.ay = 16'(ay); w.az = 24'(az);
        w.bx = 16'(bx); w.by = 16'(by); w.bz = 24'(bz);
        w.cx = 16'(cx); w.cy = 16'(cy); w.cz = 24'(cz);
        return w;
    endfunction

    function automatic cmd_word_t read_word(int col, int row);
        cmd_word_t w;
        w = blank_word(OP_READ);
        w.col = 8'(col);
        w.row = 8'(row);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    task automatic send_word(cmd_word_t w);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_op       = w.op;
        s_ax       = w.ax;  s_ay       = w.ay;  s_az = w.az;
        s_bx       = w.bx;  s_by_coord = w.by;  s_bz = w.bz;
        s_cx_coord = w.cx;  s_cy_coord = w.cy;  s_cz = w.cz;
        s_read_col = w.col; s_read_row = w.row;
        do @(posedge aclk); while (!(s_valid && s_ready));
        begin
            depth_result_t r;
            r = rasterise_word(w);
            // typed rows carry their result from the directed table
            if (w.typed) begin
                r.depth = w.typed_depth;
                r.empty = w.typed_empty;
            end
            owed_results.insert(owed_results.size(), r);
        end
        @(negedge aclk);
    endtask

    initial begin
        cmd_word_t w;
        int        anchor_x, anchor_y, clears_left, r, m;
        foreach (depth_mirror[k]) depth_mirror[k] = EMPTY_DEPTH;

        // directed table
        add_row(read_word(0, 0), 1'b1, EMPTY_DEPTH, 1'b1);
        add_row(read_word(255, 255), 1'b1, EMPTY_DEPTH, 1'b1);
        add_row(blank_word(OP_NONE), 1'b1, 24'h0, 1'b0);
        // plain right triangle at depth zero
        add_row(tri_word(160, 160, 0, 320, 160, 0, 160, 320, 0), 1'b1, 24'h0, 1'b0);
        add_row(read_word(12, 12), 1'b1, 24'h0, 1'b0);
        add_row(read_word(10, 10), 1'b0, 24'h0, 1'b0);
        add_row(read_word(19, 19), 1'b0, 24'h0, 1'b0);
        // empty-valued vertices saturate one below empty
        add_row(tri_word(640, 640, 'hFFFFFF, 800, 640, 'hFFFFFF, 640, 800, 'hFFFFFF),
                1'b1, 24'h0, 1'b0);
        add_row(read_word(42, 42), 1'b1, MAX_DRAWN, 1'b0);
        // sloped depth triangle
        add_row(tri_word(1285, 1283, 'h000100, 1570, 1400, 'hFFFFFE, 1400, 1599, 'h7F0000),
                1'b0, 24'h0, 1'b0);
        add_row(read_word(88, 88), 1'b0, 24'h0, 1'b0);
        add_row(read_word(90, 92), 1'b0, 24'h0, 1'b0);
        // coordinate extremes along x, thin in y
        add_row(tri_word(-32768, 960, 'h100000, 32767, 960, 'h800000, 0, 992, 'h010000),
                1'b0, 24'h0, 1'b0);
        add_row(read_word(0, 60), 1'b0, 24'h0, 1'b0);
        add_row(read_word(255, 60), 1'b0, 24'h0, 1'b0);
        // coordinate extremes along y, thin in x
        add_row(tri_word(1600, -32768, 'h200000, 1632, 32767, 'h300000, 1616, -32768, 'h0),
                1'b0, 24'h0, 1'b0);
        add_row(read_word(101, 128), 1'b0, 24'h0, 1'b0);
        // flat triangle: no row has two crossings
        add_row(tri_word(2000, 2008, 'h0, 3000, 2008, 'h0, 2500, 2008, 'h0),
                1'b1, 24'h0, 1'b0);
        add_row(read_word(150, 125), 1'b1, EMPTY_DEPTH, 1'b1);
        add_row(blank_word(OP_CLEAR), 1'b1, 24'h0, 1'b0);
        add_row(read_word(12, 12), 1'b1, EMPTY_DEPTH, 1'b1);
        add_row(read_word(42, 42), 1'b1, EMPTY_DEPTH, 1'b1);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[k]) send_word(directed_rows[k]);

        // random part: mostly small triangles near the store and reads near them
        anchor_x    = 64;
        anchor_y    = 64;
        clears_left = 2;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            // hold off once until the block has drained completely
            if (n == NUM_RANDOM / 2) begin
                s_valid = 1'b0;
                while (owed_results.size() != 0) @(negedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                w = blank_word(OP_DRAW);
                m = $urandom_range(0, 19);
                if (m == 0) begin
                    // thin band of rows, x anywhere
                    w.ay = 16'($urandom_range(0, 4300) - 150);
                    w.by = 16'(w.ay + $urandom_range(0, 40));
                    w.cy = 16'(w.ay + $urandom_range(0, 40));
                end else if (m == 1) begin
                    // thin band of columns, y anywhere
                    w.ax = 16'($urandom_range(0, 4300) - 150);
                    w.bx = 16'(w.ax + $urandom_range(0, 40));
                    w.cx = 16'(w.ax + $urandom_range(0, 40));
                end else begin
                    anchor_x = $urandom_range(0, 4300) - 150;
                    anchor_y = $urandom_range(0, 4300) - 150;
                    w.ax = 16'(anchor_x + $urandom_range(0, 256) - 128);
                    w.ay = 16'(anchor_y + $urandom_range(0, 256) - 128);
                    w.bx = 16'(anchor_x + $urandom_range(0, 256) - 128);
                    w.by = 16'(anchor_y + $urandom_range(0, 256) - 128);
                    w.cx = 16'(anchor_x + $urandom_range(0, 256) - 128);
                    w.cy = 16'(anchor_y + $urandom_range(0, 256) - 128);
                    if ($urandom_range(0, 9) == 0) w.az = EMPTY_DEPTH;
                    if ($urandom_range(0, 9) == 0) w.bz = 24'h0;
                end
            end else if (r < 93) begin
                w = blank_word(OP_READ);
                if ($urandom_range(0, 9) < 7) begin
                    w.col = 8'((anchor_x / 16 + $urandom_range(0, 16) - 8) & 8'hFF);
                    w.row = 8'((anchor_y / 16 + $urandom_range(0, 16) - 8) & 8'hFF);
                end
            end else if (r < 97 || clears_left == 0) begin
                w = blank_word(OP_NONE);
            end else begin
                w = blank_word(OP_CLEAR);
                clears_left--;
            end
            send_word(w);
        end
        s_valid = 1'b0;
        sending_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // receiver stalls
    // ------------------------------------------------------------------
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            stall = idle_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        depth_result_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $error("result word with nothing owed: depth %h empty %b",
                       m_read_depth, m_is_empty);
                fail_count++;
            end else begin
                exp_word = owed_results.pop_front();
                if (m_read_depth !== exp_word.depth) begin
                    $error("read_depth: expected %h, got %h", exp_word.depth, m_read_depth);
                    fail_count++;
                end
                if (m_is_empty !== exp_word.empty) begin
                    $error("is_empty: expected %b, got %b", exp_word.empty, m_is_empty);
                    fail_count++;
                end
            end
        end
    end

    // end of run: drain, let the block settle, then report
    initial begin
        wait (sending_done);
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (owed_results.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
